/* rtl/core/c_subset_tokenizer_defines.svh */
// Assertion helpers used by the checker in ctk_checker.sv.
`ifndef C_SUBSET_TOKENIZER_DEFINES_SVH
`define C_SUBSET_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CTK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctk check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CTK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctk check failed");

`endif

/* rtl/core/ctk_pkg.sv */
package ctk_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int QUEUE_DEPTH       = 4;
  localparam int NUM_KEYWORDS      = 7;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_EQ    = 3'd1,
    MODE_NUM   = 3'd2,
    MODE_IDENT = 3'd3,
    MODE_STR   = 3'd4
  } scan_mode_t;

  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_LPAREN  = 5'd8;
  localparam logic [4:0] KIND_RPAREN  = 5'd9;
  localparam logic [4:0] KIND_LBRACE  = 5'd10;
  localparam logic [4:0] KIND_RBRACE  = 5'd11;
  localparam logic [4:0] KIND_SEMI    = 5'd12;
  localparam logic [4:0] KIND_COMMA   = 5'd13;
  localparam logic [4:0] KIND_PLUS    = 5'd14;
  localparam logic [4:0] KIND_MINUS   = 5'd15;
  localparam logic [4:0] KIND_STAR    = 5'd16;
  localparam logic [4:0] KIND_SLASH   = 5'd17;
  localparam logic [4:0] KIND_EQEQ    = 5'd18;
  localparam logic [4:0] KIND_LT      = 5'd19;
  localparam logic [4:0] KIND_GT      = 5'd20;
  localparam logic [4:0] KIND_ASSIGN  = 5'd21;
  localparam logic [4:0] KIND_IDENT   = 5'd22;
  localparam logic [4:0] KIND_NUM     = 5'd23;
  localparam logic [4:0] KIND_STR     = 5'd24;
  localparam logic [4:0] KIND_UNKNOWN = 5'd25;
  localparam logic [4:0] KIND_UNTERM  = 5'd26;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword text right-aligned, first character in the highest used byte.
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'h0000_0000_0069_6E74,
    64'h0000_0000_6368_6172,
    64'h0000_0000_766F_6964,
    64'h0000_7265_7475_726E,
    64'h0000_0000_0000_6966,
    64'h0000_0000_656C_7365,
    64'h0000_0077_6869_6C65
  };
  localparam logic [15:0] KW_LEN [NUM_KEYWORDS] = '{
    16'd3, 16'd4, 16'd4, 16'd6, 16'd2, 16'd4, 16'd5
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic   a_valid;
    token_t a;
    logic   b_valid;
    token_t b;
  } lex_out_t;

  function automatic logic digit_byte(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic alpha_byte(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // Single-character punctuation; bit 5 flags a match.
  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] r;
    r = '0;
    unique case (c)
      CH_LPAREN: r = {1'b1, KIND_LPAREN};
      CH_RPAREN: r = {1'b1, KIND_RPAREN};
      CH_LBRACE: r = {1'b1, KIND_LBRACE};
      CH_RBRACE: r = {1'b1, KIND_RBRACE};
      CH_SEMI:   r = {1'b1, KIND_SEMI};
      CH_COMMA:  r = {1'b1, KIND_COMMA};
      CH_PLUS:   r = {1'b1, KIND_PLUS};
      CH_MINUS:  r = {1'b1, KIND_MINUS};
      CH_STAR:   r = {1'b1, KIND_STAR};
      CH_SLASH:  r = {1'b1, KIND_SLASH};
      CH_LT:     r = {1'b1, KIND_LT};
      CH_GT:     r = {1'b1, KIND_GT};
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/c_subset_tokenizer.sv */
// Streaming lexer for a small C subset. One source byte is taken per cycle
// while in_ready is high (byte 0 ends the input and yields the end token,
// after which position and line restart). Each request on the input decodes
// combinationally against the scanner state into tokens for a four-entry
// token queue. Most bytes give zero or one token; a byte that closes a
// pending '=', number or identifier and is itself a token gives two, as
// does byte 0 inside an open string. in_ready drops while fewer than two
// queue entries are free, so with out_ready high, bytes giving at most one
// token go in at one per cycle, the rate of the queue's single read port.
module c_subset_tokenizer #(
  parameter int POSITION_BITS = ctk_pkg::POSITION_BITS_DEF,
  parameter int KEYWORD_CHARS = ctk_pkg::KEYWORD_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_line,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  ctk_pkg::lex_out_t lex_out;
  ctk_pkg::token_t   head;
  logic              step;
  logic              room;

  assign in_ready = room;
  assign step     = in_valid && in_ready;

  ctk_lexer #(
    .POSITION_BITS (POSITION_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .source_byte (in_source_byte),
    .lex_out     (lex_out)
  );

  ctk_token_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (lex_out),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_token (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_line   = head.line;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_last_of_run  = head.last;

endmodule

/* rtl/core/ctk_lexer.sv */
module ctk_lexer #(
  parameter int POSITION_BITS = ctk_pkg::POSITION_BITS_DEF,
  parameter int KEYWORD_CHARS = ctk_pkg::KEYWORD_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        source_byte,
  output ctk_pkg::lex_out_t lex_out
);

  localparam int PB   = POSITION_BITS;
  localparam int KW_W = 8 * KEYWORD_CHARS;

  ctk_pkg::scan_mode_t mode_r, mode_nxt;
  logic [PB-1:0]       pos_r, pos_nxt, pos_inc;
  logic [PB-1:0]       pstart_r, pstart_nxt;
  logic [15:0]         line_r, line_nxt, line_inc;
  logic [15:0]         plen_r, plen_nxt, plen_inc;
  logic [KW_W-1:0]     window_r, window_nxt;
  logic [15:0]         pos16, pstart16;
  logic [4:0]          kw_kind;
  logic [5:0]          punct;
  logic [63:0]         window64;
  logic                rescan;
  logic                a_v, b_v;
  logic [4:0]          a_kind, b_kind;
  logic [15:0]         a_len;
  logic [7:0]          c;

  assign c = source_byte;

  if (PB >= 16) begin : g_pos_wide
    assign pos16    = pos_r[15:0];
    assign pstart16 = pstart_r[15:0];
  end else begin : g_pos_narrow
    assign pos16    = {{(16-PB){1'b0}}, pos_r};
    assign pstart16 = {{(16-PB){1'b0}}, pstart_r};
  end

  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + 1'b1;
  assign line_inc = (line_r == 16'hFFFF) ? line_r : line_r + 16'd1;
  assign plen_inc = (plen_r == 16'hFFFF) ? plen_r : plen_r + 16'd1;
  assign window64 = 64'(window_r);
  assign punct    = ctk_pkg::punct_kind(c);

  always_comb begin
    kw_kind = ctk_pkg::KIND_IDENT;
    if (plen_r <= 16'(KEYWORD_CHARS)) begin
      for (int i = ctk_pkg::NUM_KEYWORDS - 1; i >= 0; i--) begin
        if ((plen_r == ctk_pkg::KW_LEN[i]) && (window64 == ctk_pkg::KW_TEXT[i])) begin
          kw_kind = 5'(i + 1);
        end
      end
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    window_nxt = window_r;
    a_v        = 1'b0;
    a_kind     = ctk_pkg::KIND_END;
    a_len      = 16'd0;
    b_v        = 1'b0;
    b_kind     = ctk_pkg::KIND_END;
    rescan     = 1'b0;

    unique case (mode_r)
      ctk_pkg::MODE_EQ: begin
        mode_nxt = ctk_pkg::MODE_IDLE;
        a_v      = 1'b1;
        if (c == ctk_pkg::CH_EQ) begin
          a_kind  = ctk_pkg::KIND_EQEQ;
          pos_nxt = pos_inc;
        end else begin
          a_kind = ctk_pkg::KIND_ASSIGN;
          rescan = 1'b1;
        end
      end
      ctk_pkg::MODE_NUM: begin
        if (ctk_pkg::digit_byte(c)) begin
          plen_nxt = plen_inc;
          pos_nxt  = pos_inc;
        end else begin
          mode_nxt = ctk_pkg::MODE_IDLE;
          a_v      = 1'b1;
          a_kind   = ctk_pkg::KIND_NUM;
          a_len    = plen_r;
          rescan   = 1'b1;
        end
      end
      ctk_pkg::MODE_IDENT: begin
        if (ctk_pkg::alpha_byte(c) || ctk_pkg::digit_byte(c)) begin
          plen_nxt = plen_inc;
          pos_nxt  = pos_inc;
          if (KW_W > 8) begin
            window_nxt = {window_r[KW_W-9:0], c};
          end else begin
            window_nxt = KW_W'(c);
          end
        end else begin
          mode_nxt   = ctk_pkg::MODE_IDLE;
          a_v        = 1'b1;
          a_kind     = kw_kind;
          a_len      = plen_r;
          window_nxt = '0;
          rescan     = 1'b1;
        end
      end
      ctk_pkg::MODE_STR: begin
        if (c == ctk_pkg::CH_NUL) begin
          mode_nxt = ctk_pkg::MODE_IDLE;
          a_v      = 1'b1;
          a_kind   = ctk_pkg::KIND_UNTERM;
          a_len    = plen_r;
          rescan   = 1'b1;
        end else if (c == ctk_pkg::CH_DQUOTE) begin
          mode_nxt = ctk_pkg::MODE_IDLE;
          pos_nxt  = pos_inc;
          a_v      = 1'b1;
          a_kind   = ctk_pkg::KIND_STR;
          a_len    = plen_r;
        end else begin
          if (c == ctk_pkg::CH_LF) begin
            line_nxt = line_inc;
          end
          plen_nxt = plen_inc;
          pos_nxt  = pos_inc;
        end
      end
      ctk_pkg::MODE_IDLE: begin
        rescan = 1'b1;
      end
      default: begin
        mode_nxt = ctk_pkg::MODE_IDLE;
        rescan   = 1'b1;
      end
    endcase

    if (rescan) begin
      priority if (c == ctk_pkg::CH_NUL) begin
        b_v        = 1'b1;
        b_kind     = ctk_pkg::KIND_END;
        mode_nxt   = ctk_pkg::MODE_IDLE;
        pos_nxt    = '0;
        line_nxt   = 16'd1;
        pstart_nxt = '0;
        plen_nxt   = 16'd0;
        window_nxt = '0;
      end else if (ctk_pkg::is_space(c)) begin
        if (c == ctk_pkg::CH_LF) begin
          line_nxt = line_inc;
        end
        pos_nxt = pos_inc;
      end else if (punct[5]) begin
        b_v     = 1'b1;
        b_kind  = punct[4:0];
        pos_nxt = pos_inc;
      end else if (c == ctk_pkg::CH_EQ) begin
        pstart_nxt = pos_r;
        plen_nxt   = 16'd0;
        mode_nxt   = ctk_pkg::MODE_EQ;
        pos_nxt    = pos_inc;
      end else if (ctk_pkg::digit_byte(c)) begin
        pstart_nxt = pos_r;
        plen_nxt   = 16'd1;
        mode_nxt   = ctk_pkg::MODE_NUM;
        pos_nxt    = pos_inc;
      end else if (ctk_pkg::alpha_byte(c)) begin
        pstart_nxt = pos_r;
        plen_nxt   = 16'd1;
        window_nxt = KW_W'(c);
        mode_nxt   = ctk_pkg::MODE_IDENT;
        pos_nxt    = pos_inc;
      end else if (c == ctk_pkg::CH_DQUOTE) begin
        // string text starts after the opening quote
        pstart_nxt = pos_inc;
        plen_nxt   = 16'd0;
        mode_nxt   = ctk_pkg::MODE_STR;
        pos_nxt    = pos_inc;
      end else begin
        pstart_nxt = pos_r;
        plen_nxt   = 16'd0;
        b_v        = 1'b1;
        b_kind     = ctk_pkg::KIND_UNKNOWN;
        pos_nxt    = pos_inc;
      end
    end
  end

  always_comb begin
    lex_out.a_valid  = step && a_v;
    lex_out.a.kind   = a_kind;
    lex_out.a.line   = line_r;
    lex_out.a.start  = pstart16;
    lex_out.a.length = a_len;
    lex_out.a.last   = !b_v;
    lex_out.b_valid  = step && b_v;
    lex_out.b.kind   = b_kind;
    lex_out.b.line   = line_r;
    lex_out.b.start  = pos16;
    lex_out.b.length = 16'd0;
    lex_out.b.last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ctk_pkg::MODE_IDLE;
      pos_r    <= '0;
      line_r   <= 16'd1;
      pstart_r <= '0;
      plen_r   <= 16'd0;
      window_r <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      window_r <= window_nxt;
    end
  end

endmodule

/* rtl/core/ctk_token_queue.sv */
module ctk_token_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  ctk_pkg::lex_out_t push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ctk_pkg::token_t   out_token
);

  localparam int DEPTH = ctk_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ctk_pkg::token_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_b;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign room      = count_r <= CNT_W'(DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_token = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_b  = wr_ptr_r + PTR_W'(push.a_valid);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.a_valid) + PTR_W'(push.b_valid);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.a_valid) + CNT_W'(push.b_valid) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      mem_r[wr_ptr_r] <= push.a;
    end
    if (push.b_valid) begin
      mem_r[wr_ptr_b] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/core/ctk_checker.sv */
`include "c_subset_tokenizer_defines.svh"

module ctk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_token_kind,
  input logic [15:0] out_token_line,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic        out_last_of_run
);

  logic zero_len_kind;

  assign zero_len_kind = (out_token_kind == ctk_pkg::KIND_END) ||
                         (out_token_kind == ctk_pkg::KIND_UNKNOWN) ||
                         ((out_token_kind >= ctk_pkg::KIND_LPAREN) &&
                          (out_token_kind <= ctk_pkg::KIND_ASSIGN));

  // stalled request holds
  `CTK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_token_kind) && $stable(out_token_line) && $stable(out_token_start) && $stable(out_token_length) && $stable(out_last_of_run))

  // end closes its byte's run
  `CTK_ASSERT_IMPL(a_end_last, out_valid && (out_token_kind == ctk_pkg::KIND_END), out_last_of_run)

  // unterminated string is never last of its run, since the end token follows it
  `CTK_ASSERT_IMPL(a_unterm_not_last, out_valid && (out_token_kind == ctk_pkg::KIND_UNTERM), !out_last_of_run)

  `CTK_ASSERT_IMPL(a_zero_len, out_valid && zero_len_kind, out_token_length == 16'd0)

endmodule

bind c_subset_tokenizer ctk_checker u_ctk_checker (.*);

/* bench/ctk_token_checker.sv */
module ctk_token_checker
  import ctk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_source_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  out_token_kind,
  input  logic [15:0] out_token_line,
  input  logic [15:0] out_token_start,
  input  logic [15:0] out_token_length,
  input  logic        out_last_of_run,
  output int          mismatches,
  output int          outstanding,
  output int          bytes_seen,
  output int          tokens_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] KIND_KW_INT    = 5'd1;
  localparam logic [4:0] KIND_KW_CHAR   = 5'd2;
  localparam logic [4:0] KIND_KW_VOID   = 5'd3;
  localparam logic [4:0] KIND_KW_RETURN = 5'd4;
  localparam logic [4:0] KIND_KW_IF     = 5'd5;
  localparam logic [4:0] KIND_KW_ELSE   = 5'd6;
  localparam logic [4:0] KIND_KW_WHILE  = 5'd7;

  localparam logic [47:0] TEXT_INT    = "int";
  localparam logic [47:0] TEXT_CHAR   = "char";
  localparam logic [47:0] TEXT_VOID   = "void";
  localparam logic [47:0] TEXT_RETURN = "return";
  localparam logic [47:0] TEXT_IF     = "if";
  localparam logic [47:0] TEXT_ELSE   = "else";
  localparam logic [47:0] TEXT_WHILE  = "while";

  localparam logic [15:0] SAT16     = 16'hFFFF;
  localparam int          WORD_KEEP = 6;

  scan_mode_t  mode;
  logic [15:0] pos;
  logic [15:0] line_no;
  logic [15:0] word_start;
  logic [15:0] word_len;
  logic [47:0] word_tail;
  token_t      step_out[$];
  token_t      tokens_due[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    bytes_seen  = 0;
    tokens_seen = 0;
  end

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
           (c == CH_UNDER);
  endfunction

  task automatic clear_scanner();
    mode       = MODE_IDLE;
    pos        = '0;
    line_no    = 16'd1;
    word_start = '0;
    word_len   = '0;
    word_tail  = '0;
  endtask

  task automatic bump_pos();
    if (pos != SAT16) pos++;
  endtask

  task automatic bump_line();
    if (line_no != SAT16) line_no++;
  endtask

  task automatic grow_word();
    if (word_len != SAT16) word_len++;
  endtask

  task automatic emit_token(input logic [4:0] kind, input logic [15:0] start,
                            input logic [15:0] len);
    token_t t;
    t.kind   = kind;
    t.line   = line_no;
    t.start  = start;
    t.length = len;
    t.last   = 1'b0;
    step_out.push_back(t);
  endtask

  function automatic logic [4:0] word_kind();
    if (word_len > WORD_KEEP) return KIND_IDENT;
    case (word_tail)
      TEXT_INT:    return KIND_KW_INT;
      TEXT_CHAR:   return KIND_KW_CHAR;
      TEXT_VOID:   return KIND_KW_VOID;
      TEXT_RETURN: return KIND_KW_RETURN;
      TEXT_IF:     return KIND_KW_IF;
      TEXT_ELSE:   return KIND_KW_ELSE;
      TEXT_WHILE:  return KIND_KW_WHILE;
      default:     return KIND_IDENT;
    endcase
  endfunction

  // byte seen outside any token
  task automatic fresh_byte(input logic [7:0] c);
    logic [4:0] punct;
    punct = KIND_END;
    case (c)
      CH_LPAREN: punct = KIND_LPAREN;
      CH_RPAREN: punct = KIND_RPAREN;
      CH_LBRACE: punct = KIND_LBRACE;
      CH_RBRACE: punct = KIND_RBRACE;
      CH_SEMI:   punct = KIND_SEMI;
      CH_COMMA:  punct = KIND_COMMA;
      CH_PLUS:   punct = KIND_PLUS;
      CH_MINUS:  punct = KIND_MINUS;
      CH_STAR:   punct = KIND_STAR;
      CH_SLASH:  punct = KIND_SLASH;
      CH_LT:     punct = KIND_LT;
      CH_GT:     punct = KIND_GT;
      default:   punct = KIND_END;
    endcase
    if (c == CH_NUL) begin
      emit_token(KIND_END, pos, '0);
      clear_scanner();
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      if (c == CH_LF) bump_line();
      bump_pos();
    end else if (punct != KIND_END) begin
      emit_token(punct, pos, '0);
      bump_pos();
    end else if (c == CH_EQ) begin
      word_start = pos;
      word_len   = '0;
      mode       = MODE_EQ;
      bump_pos();
    end else if (digit_char(c)) begin
      word_start = pos;
      word_len   = 16'd1;
      mode       = MODE_NUM;
      bump_pos();
    end else if (alpha_char(c)) begin
      word_start = pos;
      word_len   = 16'd1;
      word_tail  = {40'd0, c};
      mode       = MODE_IDENT;
      bump_pos();
    end else if (c == CH_DQUOTE) begin
      bump_pos();
      word_start = pos;
      word_len   = '0;
      mode       = MODE_STR;
    end else begin
      word_start = pos;
      word_len   = '0;
      emit_token(KIND_UNKNOWN, pos, '0);
      bump_pos();
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    step_out.delete();
    case (mode)
      MODE_EQ: begin
        mode = MODE_IDLE;
        if (c == CH_EQ) begin
          emit_token(KIND_EQEQ, word_start, '0);
          bump_pos();
        end else begin
          emit_token(KIND_ASSIGN, word_start, '0);
          fresh_byte(c);
        end
      end
      MODE_NUM: begin
        if (digit_char(c)) begin
          grow_word();
          bump_pos();
        end else begin
          mode = MODE_IDLE;
          emit_token(KIND_NUM, word_start, word_len);
          fresh_byte(c);
        end
      end
      MODE_IDENT: begin
        if (alpha_char(c) || digit_char(c)) begin
          grow_word();
          word_tail = {word_tail[39:0], c};
          bump_pos();
        end else begin
          mode = MODE_IDLE;
          emit_token(word_kind(), word_start, word_len);
          word_tail = '0;
          fresh_byte(c);
        end
      end
      MODE_STR: begin
        if (c == CH_NUL) begin
          mode = MODE_IDLE;
          emit_token(KIND_UNTERM, word_start, word_len);
          fresh_byte(c);
        end else if (c == CH_DQUOTE) begin
          mode = MODE_IDLE;
          bump_pos();
          emit_token(KIND_STR, word_start, word_len);
        end else begin
          if (c == CH_LF) bump_line();
          grow_word();
          bump_pos();
        end
      end
      default: begin
        mode = MODE_IDLE;
        fresh_byte(c);
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) tokens_due.push_back(step_out[i]);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ctk mismatch at %0t, token %0d: %s", $time, tokens_seen, msg);
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("kind %0d with no token pending", out_token_kind));
    end else begin
      want = tokens_due.pop_front();
      if (out_token_kind !== want.kind)
        report_mismatch($sformatf("kind got %0d want %0d", out_token_kind, want.kind));
      if (out_token_line !== want.line)
        report_mismatch($sformatf("line got %0d want %0d", out_token_line, want.line));
      if (out_token_start !== want.start)
        report_mismatch($sformatf("start got %0d want %0d", out_token_start, want.start));
      if (out_token_length !== want.length)
        report_mismatch($sformatf("length got %0d want %0d", out_token_length, want.length));
      if (out_last_of_run !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", out_last_of_run, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scanner();
      tokens_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        tokens_seen++;
        check_token();
      end
      if (in_valid && in_ready) begin
        bytes_seen++;
        lex_byte(in_source_byte);
      end
    end
    outstanding = tokens_due.size();
  end

endmodule

/* bench/tb_c_subset_tokenizer.sv */
module tb_c_subset_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import ctk_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 950;
  localparam int CALM_TAIL    = 150;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [7:0]  in_source_byte = 8'h00;
  logic        out_ready      = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [4:0]  out_token_kind;
  logic [15:0] out_token_line;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  int mismatches;
  int outstanding;
  int bytes_seen;
  int tokens_seen;
  int cycles       = 0;
  int bytes_sent   = 0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  string      keywords [7]   = '{"int", "char", "void", "return", "if", "else", "while"};
  logic [7:0] punct_set [12] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI,
                                 CH_COMMA, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LT,
                                 CH_GT};

  c_subset_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_byte   (in_source_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  ctk_token_checker token_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_byte   (in_source_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .bytes_seen       (bytes_seen),
    .tokens_seen      (tokens_seen)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_c_subset_tokenizer: FAIL");
      $finish;
    end
  end

  // token sink: short random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // returns at a falling edge with in_valid still high
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_source_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(CH_LC_A + r);
    if (r < 52) return 8'(CH_UC_A + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_alnum();
    if ($urandom_range(0, 3) == 0) return pick_digit();
    return pick_alpha();
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0, 1, 2: return CH_SPACE;
      3:       return CH_LF;
      4:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  task automatic send_delimiter();
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 2) == 0) send_byte(punct_set[$urandom_range(0, 11)]);
      else send_byte(pick_space());
    end
  endtask

  task automatic send_piece();
    int         pick;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_text(keywords[$urandom_range(0, 6)]);
      send_delimiter();
    end else if (pick < 30) begin
      send_byte(pick_alpha());
      repeat ($urandom_range(0, 8)) send_byte(pick_alnum());
      send_delimiter();
    end else if (pick < 42) begin
      repeat ($urandom_range(1, 6)) send_byte(pick_digit());
      send_delimiter();
    end else if (pick < 54) begin
      send_byte(punct_set[$urandom_range(0, 11)]);
    end else if (pick < 60) begin
      send_byte(CH_EQ);
      if ($urandom_range(0, 1) == 1) send_byte(CH_EQ);
    end else if (pick < 70) begin
      send_byte(CH_DQUOTE);
      repeat ($urandom_range(0, 8)) begin
        ch = 8'($urandom_range(1, 255));
        if (ch == CH_DQUOTE) ch = CH_LF;
        send_byte(ch);
      end
      send_byte(CH_DQUOTE);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) send_byte(pick_space());
    end else if (pick < 90) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      send_byte(CH_NUL);
    end else begin
      send_byte(CH_DQUOTE);
      repeat ($urandom_range(0, 4)) send_byte(pick_alnum());
      send_byte(CH_NUL);
    end
  endtask

  initial begin
    int  random_end;
    bit  hold_done;
    bit  pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_byte(CH_NUL);
    send_text("int char void return if else while\n");
    send_text("(){};,+-*/<>");
    send_text("a=b==c=(9)x;");
    send_text("retur returns _Z9 abcdefg\r\t");
    send_text("\"s\tr\n\"\"\"");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_text("@#$");
    send_byte(8'h01);
    send_text("=@=\"q\"");
    send_byte(CH_NUL);
    send_text("\"ab\n");
    send_byte(CH_NUL);
    send_text("=");
    send_byte(CH_NUL);
    send_text("42");
    send_byte(CH_NUL);
    send_text("while");
    send_byte(CH_NUL);

    random_end = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_end) begin
      calm = (bytes_sent + CALM_TAIL >= random_end) || (((bytes_sent / 160) % 4) == 3);
      if (!hold_done && bytes_sent >= 400) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && bytes_sent >= 800) begin
        wait_empty();
        pause_done = 1'b1;
      end
      send_piece();
    end

    calm = 1'b1;
    send_byte(CH_NUL);
    send_text(" x9 ;");
    send_byte(CH_NUL);
    send_text("if 1");
    send_byte(CH_NUL);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("covered %0d source bytes and %0d tokens: every kind, two-token bytes,",
             bytes_seen, tokens_seen);
    $display("input ends, unterminated strings, idle bursts, long output hold-off");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_c_subset_tokenizer: PASS");
    end else begin
      $display("tb_c_subset_tokenizer: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ctk_pkg.sv
rtl/core/ctk_lexer.sv
rtl/core/ctk_token_queue.sv
rtl/core/c_subset_tokenizer.sv
rtl/core/ctk_checker.sv
bench/ctk_token_checker.sv
bench/tb_c_subset_tokenizer.sv
